// File: rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the sweep stepper scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    // Configuration register file addressing
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_VISIBLE_PERIOD = 3'd0,
        CFG_HIDDEN_PERIOD  = 3'd1,
        CFG_VISIBLE_LIMIT  = 3'd2,
        CFG_HIDDEN_LIMIT   = 3'd3,
        CFG_MEASURE_INTV   = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [CFG_DATA_WIDTH-1:0] VISIBLE_PERIOD_RST = 8'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] HIDDEN_PERIOD_RST  = 8'd10;
    localparam logic [CFG_DATA_WIDTH-1:0] VISIBLE_LIMIT_RST  = 8'd48;
    localparam logic [CFG_DATA_WIDTH-1:0] HIDDEN_LIMIT_RST   = 8'd48;
    localparam logic [CFG_DATA_WIDTH-1:0] MEASURE_INTV_RST   = 8'd10;

    // Four-phase coil drive sequence
    localparam logic [3:0] COIL_SEQ [4] = '{4'd3, 4'd6, 4'd12, 4'd9};
    localparam logic [3:0] COIL_RST     = 4'd3;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] visible_step_period;
        logic [CFG_DATA_WIDTH-1:0] hidden_step_period;
        logic [CFG_DATA_WIDTH-1:0] visible_step_limit;
        logic [CFG_DATA_WIDTH-1:0] hidden_step_limit;
        logic [CFG_DATA_WIDTH-1:0] measure_interval;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic       step_taken;
        logic       measure_request;
        logic [7:0] measure_index;
        logic       in_hidden_section;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/sweep_stepper_scheduler.sv
// ----------------------------------------------------------------------------
// sweep_stepper_scheduler
// Four-phase stepper sweep sequencer with measurement request pacing.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  -------  --------------------  ----------------------------------------
//  input    in_valid / in_ready   tick
//  output   out_valid / out_ready coil_pattern, step_taken, measure_request,
//                                 measure_index, in_hidden_section
//  config   cfg_valid / cfg_ready cfg_index (3b), cfg_data (8b)
//
//  One tick per cycle while in_ready is high; its result is registered in the
//  output register, or in the skid entry while a result is stalled. The step
//  logic is one pass between the state registers and the result register. The
//  skid entry lets one further tick be taken while a result is stalled;
//  in_ready drops only when both entries are full. Reset loads the register
//  defaults and the first coil pattern; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module sweep_stepper_scheduler
    import sss_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       tick,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [3:0]                      coil_pattern,
    output logic                            step_taken,
    output logic                            measure_request,
    output logic [7:0]                      measure_index,
    output logic                            in_hidden_section,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_data;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid & in_ready;

    sss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sss_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .tick   (tick),
        .cfg    (cfg),
        .result (core_result)
    );

    sss_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign coil_pattern      = out_data.coil_pattern;
    assign step_taken        = out_data.step_taken;
    assign measure_request   = out_data.measure_request;
    assign measure_index     = out_data.measure_index;
    assign in_hidden_section = out_data.in_hidden_section;

endmodule

`default_nettype wire

// File: rtl/sss_cfg_regs.sv
// ----------------------------------------------------------------------------
// sss_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_cfg_regs
    import sss_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_VISIBLE_PERIOD: cfg_next.visible_step_period = wr_data;
                CFG_HIDDEN_PERIOD:  cfg_next.hidden_step_period  = wr_data;
                CFG_VISIBLE_LIMIT:  cfg_next.visible_step_limit  = wr_data;
                CFG_HIDDEN_LIMIT:   cfg_next.hidden_step_limit   = wr_data;
                CFG_MEASURE_INTV:   cfg_next.measure_interval    = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.visible_step_period <= VISIBLE_PERIOD_RST;
            cfg_reg.hidden_step_period  <= HIDDEN_PERIOD_RST;
            cfg_reg.visible_step_limit  <= VISIBLE_LIMIT_RST;
            cfg_reg.hidden_step_limit   <= HIDDEN_LIMIT_RST;
            cfg_reg.measure_interval    <= MEASURE_INTV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/sss_core.sv
// ----------------------------------------------------------------------------
// sss_core
// Sequencer state and single-pass step logic; one tick updated per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_core
    import sss_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic tick,
    input  cfg_t      cfg,
    output result_t   result
);

    logic [COUNT_WIDTH-1:0] tick_count_reg,    tick_count_next;
    logic [COUNT_WIDTH-1:0] step_count_reg,    step_count_next;
    logic [COUNT_WIDTH-1:0] measure_count_reg, measure_count_next;
    logic [1:0]             phase_index_reg,   phase_index_next;
    logic                   hidden_flag_reg,   hidden_flag_next;
    logic [7:0]             angle_index_reg,   angle_index_next;
    logic [3:0]             coil_reg,          coil_next;

    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] limit;
    logic [COUNT_WIDTH-1:0] interval;
    logic                   stepped;
    logic                   req;
    logic [7:0]             idx;

    // Select section timing and compute next state
    always_comb
    begin
        period   = hidden_flag_reg ? COUNT_WIDTH'(cfg.hidden_step_period)
                                   : COUNT_WIDTH'(cfg.visible_step_period);
        limit    = hidden_flag_reg ? COUNT_WIDTH'(cfg.hidden_step_limit)
                                   : COUNT_WIDTH'(cfg.visible_step_limit);
        interval = COUNT_WIDTH'(cfg.measure_interval);

        tick_count_next    = tick_count_reg;
        step_count_next    = step_count_reg;
        measure_count_next = measure_count_reg;
        phase_index_next   = phase_index_reg;
        hidden_flag_next   = hidden_flag_reg;
        angle_index_next   = angle_index_reg;
        coil_next          = coil_reg;
        stepped            = 1'b0;
        req                = 1'b0;
        idx                = '0;

        if (tick)
        begin
            if (tick_count_reg >= period)
            begin
                stepped          = 1'b1;
                tick_count_next  = '0;
                coil_next        = COIL_SEQ[phase_index_reg];
                phase_index_next = phase_index_reg + 2'd1;

                // Measurement pacing in the visible section
                if (!hidden_flag_reg)
                begin
                    if (measure_count_reg == interval)
                    begin
                        measure_count_next = '0;
                        req                = 1'b1;
                        idx                = angle_index_reg;
                        angle_index_next   = angle_index_reg + 8'd1;
                    end
                    else
                    begin
                        measure_count_next = measure_count_reg + COUNT_WIDTH'(1);
                    end
                end

                // Section switch at the step limit
                if (step_count_reg >= limit)
                begin
                    step_count_next = '0;
                    if (hidden_flag_reg)
                    begin
                        angle_index_next = '0;
                        hidden_flag_next = 1'b0;
                    end
                    else
                    begin
                        hidden_flag_next = 1'b1;
                    end
                end
                else
                begin
                    step_count_next = step_count_reg + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                tick_count_next = tick_count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    // Advance state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            step_count_reg    <= '0;
            measure_count_reg <= '0;
            phase_index_reg   <= '0;
            hidden_flag_reg   <= 1'b0;
            angle_index_reg   <= '0;
            coil_reg          <= COIL_RST;
        end
        else if (accept)
        begin
            tick_count_reg    <= tick_count_next;
            step_count_reg    <= step_count_next;
            measure_count_reg <= measure_count_next;
            phase_index_reg   <= phase_index_next;
            hidden_flag_reg   <= hidden_flag_next;
            angle_index_reg   <= angle_index_next;
            coil_reg          <= coil_next;
        end
    end

    assign result.coil_pattern      = coil_next;
    assign result.step_taken        = stepped;
    assign result.measure_request   = req;
    assign result.measure_index     = idx;
    assign result.in_hidden_section = hidden_flag_next;

endmodule

`default_nettype wire

// File: rtl/sss_out_buf.sv
// ----------------------------------------------------------------------------
// sss_out_buf
// Result register with a skid entry, so one further input is taken during a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_out_buf
    import sss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  result_t   push_data,
    output logic      push_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg,   out_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    pop;

    assign pop = out_valid_reg & out_ready;

    // Route new results into the output or the skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds carry no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/sss_checker.sv
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] coil_pattern,
    input wire logic       step_taken,
    input wire logic       measure_request,
    input wire logic [7:0] measure_index
);

    // A request only comes with a step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && measure_request |-> step_taken)
        else $error("measure request without step");

    // Index reads zero when no request is raised
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !measure_request |-> measure_index == 8'd0)
        else $error("measure index nonzero without request");

    // Coil drive is always a sequence pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coil_pattern == 4'd3 || coil_pattern == 4'd6 ||
                       coil_pattern == 4'd12 || coil_pattern == 4'd9))
        else $error("coil pattern outside sequence");

    // Input stalls only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coil_pattern)
            && $stable(step_taken) && $stable(measure_request)
            && $stable(measure_index))
        else $error("stalled result changed");

endmodule

bind sweep_stepper_scheduler sss_checker u_sss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .coil_pattern    (coil_pattern),
    .step_taken      (step_taken),
    .measure_request (measure_request),
    .measure_index   (measure_index)
);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sweep stepper scheduler. Ticks go in over a
// valid/ready channel, and every result is checked field by field against a
// cycle-free model of the sweep kept in the bench. Registers are rewritten
// between phases while the block is idle. Phases cover reset state, fast
// sweeps, register extremes, random sweeps and output back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
    import sss_pkg::*;

    localparam int CW = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [3:0] step_coils [4] = '{4'd3, 4'd6, 4'd12, 4'd9};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       tick;
    logic                       out_valid;
    logic                       out_ready;
    logic [3:0]                 coil_pattern;
    logic                       step_taken;
    logic                       measure_request;
    logic [7:0]                 measure_index;
    logic                       in_hidden_section;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // Sweep model state and register copy
    cfg_t          sweep_cfg;
    logic [CW-1:0] tick_acc;
    logic [CW-1:0] step_acc;
    logic [CW-1:0] meas_acc;
    logic [1:0]    phase_sel;
    logic          hidden_mode;
    logic [7:0]    angle_ctr;
    logic [3:0]    coil_now;

    result_t sweep_out_due [$];

    // Bench controls and statistics
    bit          src_gaps_on;
    bit          sink_stalls_on;
    int unsigned sink_hold;
    int unsigned mismatches;
    int unsigned n_items, n_idle_items, n_steps, n_requests, n_switches, n_cfg_writes;

    sweep_stepper_scheduler #(
        .COUNT_WIDTH(CW)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .tick             (tick),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .coil_pattern     (coil_pattern),
        .step_taken       (step_taken),
        .measure_request  (measure_request),
        .measure_index    (measure_index),
        .in_hidden_section(in_hidden_section),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Pick an idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Advance the sweep model by one input and queue the result it implies
    task automatic advance_sweep(input bit t);
        result_t       r;
        logic [CW-1:0] period;
        logic [CW-1:0] limit;
        r = '0;
        n_items++;
        if (!t)
            n_idle_items++;
        else
        begin
            period = hidden_mode ? sweep_cfg.hidden_step_period : sweep_cfg.visible_step_period;
            limit  = hidden_mode ? sweep_cfg.hidden_step_limit  : sweep_cfg.visible_step_limit;
            if (tick_acc >= period)
            begin
                tick_acc     = '0;
                r.step_taken = 1'b1;
                coil_now     = step_coils[phase_sel];
                phase_sel    = phase_sel + 2'd1;
                n_steps++;
                // Measurement pacing runs only on the visible half
                if (!hidden_mode)
                begin
                    if (meas_acc == sweep_cfg.measure_interval)
                    begin
                        meas_acc          = '0;
                        r.measure_request = 1'b1;
                        r.measure_index   = angle_ctr;
                        angle_ctr         = angle_ctr + 8'd1;
                        n_requests++;
                    end
                    else
                        meas_acc = meas_acc + CW'(1);
                end
                // Switch section once the step limit is reached
                if (step_acc >= limit)
                begin
                    step_acc = '0;
                    n_switches++;
                    if (hidden_mode)
                    begin
                        angle_ctr   = '0;
                        hidden_mode = 1'b0;
                    end
                    else
                        hidden_mode = 1'b1;
                end
                else
                    step_acc = step_acc + CW'(1);
            end
            else
                tick_acc = tick_acc + CW'(1);
        end
        r.coil_pattern      = coil_now;
        r.in_hidden_section = hidden_mode;
        sweep_out_due.push_back(r);
    endtask

    // Offer one tick; valid is left high so a back-to-back tick needs no toggle
    task automatic send_tick(input bit t);
        int unsigned gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        advance_sweep(t);
    endtask

    // Drop valid right after the last transfer of a burst
    task automatic release_ticks();
        in_valid <= 1'b0;
    endtask

    // Offer a burst of ticks and keep valid up after the last one
    task automatic send_ticks(input int n, input int unsigned one_pct);
        int i;
        for (i = 0; i < n; i++)
            send_tick($urandom_range(0, 99) < one_pct);
    endtask

    task automatic run_ticks(input int n, input int unsigned one_pct);
        send_ticks(n, one_pct);
        release_ticks();
    endtask

    // Wait until every queued result has come out, then let the pipe settle
    task automatic drain_results();
        do
            @(posedge clk);
        while (sweep_out_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_VISIBLE_PERIOD: sweep_cfg.visible_step_period = data;
            CFG_HIDDEN_PERIOD:  sweep_cfg.hidden_step_period  = data;
            CFG_VISIBLE_LIMIT:  sweep_cfg.visible_step_limit  = data;
            CFG_HIDDEN_LIMIT:   sweep_cfg.hidden_step_limit   = data;
            CFG_MEASURE_INTV:   sweep_cfg.measure_interval    = data;
            default: ;
        endcase
    endtask

    task automatic load_sweep_cfg(input logic [7:0] vp, input logic [7:0] hp,
                                  input logic [7:0] vl, input logic [7:0] hl,
                                  input logic [7:0] mi);
        write_reg(CFG_VISIBLE_PERIOD, vp);
        write_reg(CFG_HIDDEN_PERIOD, hp);
        write_reg(CFG_VISIBLE_LIMIT, vl);
        write_reg(CFG_HIDDEN_LIMIT, hl);
        write_reg(CFG_MEASURE_INTV, mi);
    endtask

    // Defaults straight out of reset: slow visible period, no step yet
    task automatic test_reset_state();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        release_ticks();
        drain_results();
    endtask

    // Step on every tick: first step repeats the first pattern, a request on
    // each visible step, both section switches, idle inputs, spare registers
    task automatic test_fast_sweep();
        bit seq [12] = '{1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1};
        int i;
        load_sweep_cfg(8'd0, 8'd0, 8'd2, 8'd1, 8'd0);
        write_reg(CFG_SPARE_LO, 8'hA5);
        write_reg(CFG_SPARE_HI, 8'h5A);
        for (i = 0; i < 12; i++)
            send_tick(seq[i]);
        release_ticks();
        drain_results();
        // Requests spaced by a nonzero interval
        load_sweep_cfg(8'd1, 8'd0, 8'd3, 8'd0, 8'd2);
        run_ticks(10, 100);
        drain_results();
    endtask

    // All registers at their lowest, then all at their highest
    task automatic test_register_extremes();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        load_sweep_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_ticks(40, 90);
        drain_results();
        load_sweep_cfg(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        run_ticks(260, 100);
        drain_results();
    endtask

    // Short random periods and limits so many sweeps complete
    task automatic test_random_sweeps();
        int p;
        for (p = 0; p < 4; p++)
        begin
            src_gaps_on    = (p != 1);
            sink_stalls_on = (p != 1) && (p != 2);
            load_sweep_cfg(8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)),
                           8'($urandom_range(0, 12)), 8'($urandom_range(0, 6)),
                           8'($urandom_range(0, 4)));
            if (p == 3)
                write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          8'($urandom_range(0, 255)));
            run_ticks(50, 85);
            drain_results();
        end
    endtask

    // Hold the output long enough to fill the block, then pause the sender
    // mid-stream until every result is back
    task automatic test_backpressure();
        load_sweep_cfg(8'd1, 8'd0, 8'd4, 8'd2, 8'd1);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        sink_hold      = 48;
        send_ticks(16, 100);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        run_ticks(12, 90);
        drain_results();
        run_ticks(12, 90);
        drain_results();
    endtask

    // Output ready: random stalls, plus a long hold when one is requested
    initial
    begin : drive_ready
        int unsigned stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                stall_left = sink_hold;
                sink_hold  = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Compare each result transfer with the oldest queued result
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sweep_out_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result transfer with nothing queued", $realtime);
            end
            else
            begin
                want = sweep_out_due.pop_front();
                report_field("coil_pattern", 32'(want.coil_pattern), 32'(coil_pattern));
                report_field("step_taken", 32'(want.step_taken), 32'(step_taken));
                report_field("measure_request", 32'(want.measure_request),
                             32'(measure_request));
                report_field("measure_index", 32'(want.measure_index), 32'(measure_index));
                report_field("in_hidden_section", 32'(want.in_hidden_section),
                             32'(in_hidden_section));
            end
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        tick           = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        sink_hold      = 0;
        mismatches     = 0;
        n_items        = 0;
        n_idle_items   = 0;
        n_steps        = 0;
        n_requests     = 0;
        n_switches     = 0;
        n_cfg_writes   = 0;
        sweep_cfg      = '{8'd100, 8'd10, 8'd48, 8'd48, 8'd10};
        tick_acc       = '0;
        step_acc       = '0;
        meas_acc       = '0;
        phase_sel      = '0;
        hidden_mode    = 1'b0;
        angle_ctr      = '0;
        coil_now       = 4'd3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_fast_sweep();
        test_register_extremes();
        test_random_sweeps();
        test_backpressure();
        drain_results();

        $display("Sent %0d inputs (%0d without tick) across %0d register writes.",
                 n_items, n_idle_items, n_cfg_writes);
        $display("Saw %0d steps, %0d measurement requests, %0d section changes.",
                 n_steps, n_requests, n_switches);
        if (mismatches == 0 && sweep_out_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
